### rtl/core/slfc_pkg.sv
`default_nettype none

package slfc_pkg;

  // Table geometry
  localparam int SLFC_ENTRIES = 128;

  // Field widths
  localparam int OP_W   = 2;
  localparam int PAGE_W = 64;
  localparam int SEG_W  = 32;
  localparam int MOVE_W = 64;
  localparam int STAT_W = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_EXACT      = 2'd0;
  localparam logic [OP_W-1:0] OP_FLOOR      = 2'd1;
  localparam logic [OP_W-1:0] OP_INSERT     = 2'd2;
  localparam logic [OP_W-1:0] OP_INVALIDATE = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic              valid;
    logic [PAGE_W-1:0] key;
    logic [SEG_W-1:0]  seg;
  } slfc_entry_t;

  localparam int ENTRY_W = $bits(slfc_entry_t);

  // Flags from the shared compare unit
  typedef struct packed {
    logic ab_eq;
    logic ab_lt;
    logic cd_lt;
  } slfc_cmp_t;

endpackage

`default_nettype wire

### rtl/core/slfc_ram.sv
`default_nettype none

module slfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/slfc_cmp.sv
`default_nettype none

module slfc_cmp
  import slfc_pkg::*;
(
  input  wire logic [PAGE_W-1:0] a,
  input  wire logic [PAGE_W-1:0] b,
  input  wire logic [PAGE_W-1:0] c,
  input  wire logic [PAGE_W-1:0] d,
  output slfc_cmp_t              flags
);

  // Unsigned magnitude compares shared by the check and scan phases of the sequencer
  always_comb begin
    flags.ab_eq = (a == b);
    flags.ab_lt = (a < b);
    flags.cd_lt = (c < d);
  end

endmodule

`default_nettype wire

### rtl/core/segment_location_floor_cache.sv
// Every operation, invalidate included, strobes one result when its work ends. A lookup or insert
// scans every table entry through the single RAM read port, as does a purge; a clearing
// invalidate sweeps every entry to invalid, and one that changes nothing goes straight to finish.
// Busy covers the whole item, the finish state included; a new start is taken in the cycle the
// previous result is strobed. The receiver cannot stall.
// Reset: synchronous; busy stays high while a clearing pass empties the table.
`default_nettype none

module segment_location_floor_cache
  import slfc_pkg::*;
#(
  parameter int ENTRIES = SLFC_ENTRIES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [OP_W-1:0]   in_operation,
  input  wire logic [PAGE_W-1:0] in_page_number,
  input  wire logic [SEG_W-1:0]  in_segment_number,
  input  wire logic [MOVE_W-1:0] in_move_count,
  input  wire logic              cfg_wr_en,
  input  wire logic [MOVE_W-1:0] cfg_wr_data,
  output logic                   out_strobe,
  output logic [STAT_W-1:0]      out_status,
  output logic [PAGE_W-1:0]      out_found_page,
  output logic [SEG_W-1:0]       out_found_segment
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_FINISH = 3'd3;
  localparam logic [2:0] S_CLEAR  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              item_r, item_nxt;
  logic              rvalid_r, rvalid_nxt;
  logic [AW-1:0]     raddr_r, raddr_nxt;

  logic [OP_W-1:0]   op_r, op_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [SEG_W-1:0]  seg_r, seg_nxt;
  logic [MOVE_W-1:0] move_r, move_nxt;

  logic [MOVE_W-1:0] cur_moves_r, cur_moves_nxt;
  logic [PAGE_W-1:0] oldest_r, oldest_nxt;

  logic              hit_r, hit_nxt;
  logic [AW-1:0]     hit_idx_r, hit_idx_nxt;
  logic [SEG_W-1:0]  hit_seg_r, hit_seg_nxt;
  logic              free_r, free_nxt;
  logic [AW-1:0]     free_idx_r, free_idx_nxt;
  logic              best_r, best_nxt;
  logic [PAGE_W-1:0] best_key_r, best_key_nxt;
  logic [SEG_W-1:0]  best_seg_r, best_seg_nxt;

  logic              out_strobe_r, out_strobe_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [PAGE_W-1:0] out_page_r, out_page_nxt;
  logic [SEG_W-1:0]  out_seg_r, out_seg_nxt;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  slfc_entry_t       wr_ent;
  logic              rd_en;
  slfc_entry_t       rd_ent;

  logic [PAGE_W-1:0] cmp_a, cmp_b, cmp_c, cmp_d;
  slfc_cmp_t         cmp;

  // Table storage: valid bit, key and segment in one word
  slfc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_ent),
    .rd_en   (rd_en),
    .rd_addr (cnt_r[AW-1:0]),
    .rd_data (rd_ent)
  );

  // Steer the shared comparator: generation check, or entry against query and best so far
  always_comb begin
    if (state_r == S_CHECK) begin
      cmp_a = move_r;
      cmp_b = cur_moves_r;
      cmp_c = oldest_r;
      cmp_d = page_r;
    end else begin
      cmp_a = rd_ent.key;
      cmp_b = page_r;
      cmp_c = best_key_r;
      cmp_d = rd_ent.key;
    end
  end

  slfc_cmp u_cmp (
    .a     (cmp_a),
    .b     (cmp_b),
    .c     (cmp_c),
    .d     (cmp_d),
    .flags (cmp)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    item_nxt       = item_r;
    rvalid_nxt     = 1'b0;
    raddr_nxt      = raddr_r;
    op_nxt         = op_r;
    page_nxt       = page_r;
    seg_nxt        = seg_r;
    move_nxt       = move_r;
    cur_moves_nxt  = cur_moves_r;
    oldest_nxt     = oldest_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_seg_nxt    = hit_seg_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    best_nxt       = best_r;
    best_key_nxt   = best_key_r;
    best_seg_nxt   = best_seg_r;
    out_strobe_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_page_nxt   = out_page_r;
    out_seg_nxt    = out_seg_r;
    wr_en          = 1'b0;
    wr_addr        = cnt_r[AW-1:0];
    wr_ent         = '0;
    rd_en          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        // Latch the transfer and reset the scan trackers
        if (start) begin
          op_nxt    = in_operation;
          page_nxt  = in_page_number;
          seg_nxt   = in_segment_number;
          move_nxt  = in_move_count;
          item_nxt  = 1'b1;
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          best_nxt  = 1'b0;
          cnt_nxt   = '0;
          state_nxt = (in_operation == OP_INVALIDATE) ? S_CHECK : S_SCAN;
        end
      end
      S_CHECK: begin
        // Changed generation: clear all; same generation and advancing start: purge; else no change
        cnt_nxt = '0;
        if (!cmp.ab_eq) begin
          cur_moves_nxt = move_r;
          oldest_nxt    = page_r;
          state_nxt     = S_CLEAR;
        end else if (cmp.cd_lt) begin
          oldest_nxt = page_r;
          state_nxt  = S_SCAN;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SCAN: begin
        // Issue the next read
        if (cnt_r != CW'(ENTRIES)) begin
          rd_en      = 1'b1;
          rvalid_nxt = 1'b1;
          raddr_nxt  = cnt_r[AW-1:0];
          cnt_nxt    = cnt_r + CW'(1);
        end else begin
          state_nxt = S_FINISH;
        end
        // Evaluate the entry read last cycle
        if (rvalid_r) begin
          case (op_r)
            OP_EXACT: begin
              if (rd_ent.valid && cmp.ab_eq && !hit_r) begin
                hit_nxt     = 1'b1;
                hit_seg_nxt = rd_ent.seg;
              end
            end
            OP_FLOOR: begin
              if (rd_ent.valid && (cmp.ab_lt || cmp.ab_eq) && (!best_r || cmp.cd_lt)) begin
                best_nxt     = 1'b1;
                best_key_nxt = rd_ent.key;
                best_seg_nxt = rd_ent.seg;
              end
            end
            OP_INSERT: begin
              if (rd_ent.valid && cmp.ab_eq && !hit_r) begin
                hit_nxt     = 1'b1;
                hit_idx_nxt = raddr_r;
              end
              if (!rd_ent.valid && !free_r) begin
                free_nxt     = 1'b1;
                free_idx_nxt = raddr_r;
              end
            end
            default: begin
              // Drop keys below the new oldest start
              if (rd_ent.valid && cmp.ab_lt) begin
                wr_en        = 1'b1;
                wr_addr      = raddr_r;
                wr_ent.valid = 1'b0;
                wr_ent.key   = rd_ent.key;
                wr_ent.seg   = rd_ent.seg;
              end
            end
          endcase
        end
      end
      S_FINISH: begin
        // Commit an insert and register the result
        out_strobe_nxt = 1'b1;
        out_status_nxt = ST_OK;
        out_page_nxt   = '0;
        out_seg_nxt    = '0;
        case (op_r)
          OP_EXACT: begin
            if (hit_r) begin
              out_page_nxt = page_r;
              out_seg_nxt  = hit_seg_r;
            end else begin
              out_status_nxt = ST_MISS;
            end
          end
          OP_FLOOR: begin
            if (best_r) begin
              out_page_nxt = best_key_r;
              out_seg_nxt  = best_seg_r;
            end else begin
              out_status_nxt = ST_MISS;
            end
          end
          OP_INSERT: begin
            if (hit_r || free_r) begin
              wr_en        = 1'b1;
              wr_addr      = hit_r ? hit_idx_r : free_idx_r;
              wr_ent.valid = 1'b1;
              wr_ent.key   = page_r;
              wr_ent.seg   = seg_r;
            end else begin
              out_status_nxt = ST_FULL;
            end
          end
          default: begin
          end
        endcase
        item_nxt  = 1'b0;
        state_nxt = S_IDLE;
      end
      S_CLEAR: begin
        // Sweep one entry per cycle to invalid
        wr_en   = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(ENTRIES - 1)) begin
          state_nxt = item_r ? S_FINISH : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Configuration write loads the live generation count
    if (cfg_wr_en) begin
      cur_moves_nxt = cfg_wr_data;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cnt_r        <= '0;
      item_r       <= 1'b0;
      rvalid_r     <= 1'b0;
      cur_moves_r  <= '0;
      oldest_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      item_r       <= item_nxt;
      rvalid_r     <= rvalid_nxt;
      cur_moves_r  <= cur_moves_nxt;
      oldest_r     <= oldest_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload and scan trackers
  always_ff @(posedge clk) begin
    raddr_r      <= raddr_nxt;
    op_r         <= op_nxt;
    page_r       <= page_nxt;
    seg_r        <= seg_nxt;
    move_r       <= move_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_seg_r    <= hit_seg_nxt;
    free_r       <= free_nxt;
    free_idx_r   <= free_idx_nxt;
    best_r       <= best_nxt;
    best_key_r   <= best_key_nxt;
    best_seg_r   <= best_seg_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    out_seg_r    <= out_seg_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_strobe        = out_strobe_r;
  assign out_status        = out_status_r;
  assign out_found_page    = out_page_r;
  assign out_found_segment = out_seg_r;

endmodule

`default_nettype wire

### rtl/core/slfc_checker.sv
`default_nettype none

module slfc_checker
  import slfc_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_strobe,
  input wire logic [STAT_W-1:0] out_status,
  input wire logic [PAGE_W-1:0] out_found_page,
  input wire logic [SEG_W-1:0]  out_found_segment
);

  // Reset starts the clearing pass
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low after reset");

  // A transfer keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("not busy after transfer");

  // A result comes right as the item's work ends
  a_strobe_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy && $past(busy))
    else $error("result strobe outside end of item");

  // No result strobe on consecutive cycles
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe on consecutive cycles");

  // A miss carries no entry
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status == ST_MISS |-> out_found_page == '0 && out_found_segment == '0)
    else $error("miss with nonzero payload");

endmodule

bind segment_location_floor_cache slfc_checker u_slfc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_strobe        (out_strobe),
  .out_status        (out_status),
  .out_found_page    (out_found_page),
  .out_found_segment (out_found_segment)
);

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import slfc_pkg::*;

  localparam logic [PAGE_W-1:0] ALL_PAGES  = {PAGE_W{1'b1}};
  localparam logic [PAGE_W-1:0] HIGH_PAGE  = {1'b1, {(PAGE_W-1){1'b0}}};
  localparam logic [SEG_W-1:0]  ALL_SEGS   = {SEG_W{1'b1}};
  localparam logic [MOVE_W-1:0] ALL_MOVES  = {MOVE_W{1'b1}};
  localparam int                SHOW_LIMIT = 10;

  // One expected reply of the cache
  typedef struct {
    logic [STAT_W-1:0] status;
    logic [PAGE_W-1:0] page;
    logic [SEG_W-1:0]  seg;
  } cache_reply_t;

  // Shadow copy of the segment table; predicts one reply per transfer
  class floor_cache_tracker;
    bit              slot_used [SLFC_ENTRIES];
    bit [PAGE_W-1:0] slot_page [SLFC_ENTRIES];
    bit [SEG_W-1:0]  slot_seg  [SLFC_ENTRIES];
    bit [MOVE_W-1:0] move_gen;
    bit [PAGE_W-1:0] oldest_page;
    cache_reply_t    pending_replies[$];
    int              error_count;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      move_gen    = '0;
      oldest_page = '0;
      error_count = 0;
    endfunction

    function void note_failure(string msg);
      error_count++;
      if (error_count <= SHOW_LIMIT) $display("[%0t] %s", $realtime, msg);
    endfunction

    function void load_move_count(logic [MOVE_W-1:0] value);
      move_gen = value;
    endfunction

    function int find_page(logic [PAGE_W-1:0] page);
      for (int i = 0; i < SLFC_ENTRIES; i++)
        if (slot_used[i] && slot_page[i] == page) return i;
      return -1;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [PAGE_W-1:0] page,
                               logic [SEG_W-1:0] seg, logic [MOVE_W-1:0] moves);
      cache_reply_t reply;
      int           hit;
      reply.status = ST_OK;
      reply.page   = '0;
      reply.seg    = '0;
      case (op)
        OP_EXACT: begin
          hit = find_page(page);
          if (hit >= 0) begin
            reply.page = page;
            reply.seg  = slot_seg[hit];
          end else begin
            reply.status = ST_MISS;
          end
        end
        OP_FLOOR: begin
          // greatest key not above the query page
          hit = -1;
          for (int i = 0; i < SLFC_ENTRIES; i++)
            if (slot_used[i] && slot_page[i] <= page &&
                (hit < 0 || slot_page[i] > slot_page[hit])) hit = i;
          if (hit >= 0) begin
            reply.page = slot_page[hit];
            reply.seg  = slot_seg[hit];
          end else begin
            reply.status = ST_MISS;
          end
        end
        OP_INSERT: begin
          // overwrite a matching key, else take the lowest free slot
          hit = find_page(page);
          for (int i = 0; i < SLFC_ENTRIES && hit < 0; i++)
            if (!slot_used[i]) hit = i;
          if (hit >= 0) begin
            slot_used[hit] = 1'b1;
            slot_page[hit] = page;
            slot_seg[hit]  = seg;
          end else begin
            reply.status = ST_FULL;
          end
        end
        default: begin
          // new move generation drops everything; same one purges old keys
          if (moves != move_gen) begin
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            move_gen    = moves;
            oldest_page = page;
          end else if (page > oldest_page) begin
            foreach (slot_used[i])
              if (slot_used[i] && slot_page[i] < page) slot_used[i] = 1'b0;
            oldest_page = page;
          end
        end
      endcase
      pending_replies.push_back(reply);
    endfunction

    function void check_reply(logic [STAT_W-1:0] status, logic [PAGE_W-1:0] page,
                              logic [SEG_W-1:0] seg);
      cache_reply_t want;
      if (pending_replies.size() == 0) begin
        note_failure($sformatf("unexpected result: status %0d page %h seg %h",
                               status, page, seg));
        return;
      end
      want = pending_replies.pop_front();
      if (status !== want.status || page !== want.page || seg !== want.seg)
        note_failure($sformatf(
          "mismatch: exp status %0d page %h seg %h, got status %0d page %h seg %h",
          want.status, want.page, want.seg, status, page, seg));
    endfunction

    function void close_out();
      if (pending_replies.size() != 0)
        note_failure($sformatf("%0d results never arrived", pending_replies.size()));
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [OP_W-1:0]   in_operation;
  logic [PAGE_W-1:0] in_page_number;
  logic [SEG_W-1:0]  in_segment_number;
  logic [MOVE_W-1:0] in_move_count;
  logic              cfg_wr_en;
  logic [MOVE_W-1:0] cfg_wr_data;
  logic              out_strobe;
  logic [STAT_W-1:0] out_status;
  logic [PAGE_W-1:0] out_found_page;
  logic [SEG_W-1:0]  out_found_segment;

  floor_cache_tracker cache_tracker = new();

  // Key pool of the current phase
  logic [PAGE_W-1:0] key_base;
  logic [PAGE_W-1:0] key_stride;
  int unsigned       fill_cursor;
  int                idle_pct;

  segment_location_floor_cache i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_page_number    (in_page_number),
    .in_segment_number (in_segment_number),
    .in_move_count     (in_move_count),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_found_page    (out_found_page),
    .out_found_segment (out_found_segment)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Check each strobed result, then note the transfer of a new item
  always @(posedge clk) begin
    if (rst_n && out_strobe)
      cache_tracker.check_reply(out_status, out_found_page, out_found_segment);
    if (rst_n && start && !busy)
      cache_tracker.note_request(in_operation, in_page_number, in_segment_number,
                                 in_move_count);
  end

  // Hold the item until it transfers; idle before it when asked
  task automatic send_item(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] page,
                           input logic [SEG_W-1:0] seg, input logic [MOVE_W-1:0] moves);
    @(negedge clk);
    if (idle_pct > 0 && $urandom_range(7) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 160)) @(negedge clk);
    end
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start             = 1'b1;
    in_operation      = op;
    in_page_number    = page;
    in_segment_number = seg;
    in_move_count     = moves;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait until every reply is in and the block is idle
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (cache_tracker.pending_replies.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_move_count(input logic [MOVE_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(posedge clk);
    cache_tracker.load_move_count(value);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic rebase_keys();
    key_base    = {$urandom, $urandom};
    key_stride  = ($urandom_range(3) == 0) ? 64'd1 : 64'($urandom_range(2, 1000));
    fill_cursor = 0;
  endtask

  // Mostly keys from the pool, some neighbors, extremes and wild values
  function automatic logic [PAGE_W-1:0] pick_page();
    logic [PAGE_W-1:0] pool_page;
    pool_page = key_base + $urandom_range(255) * key_stride;
    case ($urandom_range(9))
      0: return {$urandom, $urandom};
      1: begin
        case ($urandom_range(3))
          0:       return '0;
          1:       return ALL_PAGES;
          2:       return HIGH_PAGE;
          default: return ~HIGH_PAGE;
        endcase
      end
      2:       return pool_page + 1;
      3:       return pool_page - 1;
      default: return pool_page;
    endcase
  endfunction

  task automatic run_phase(input int count, input bit fill_mode);
    logic [OP_W-1:0]   op;
    logic [PAGE_W-1:0] page;
    logic [SEG_W-1:0]  seg;
    logic [MOVE_W-1:0] moves;
    int                roll;
    for (int n = 0; n < count; n++) begin
      roll  = $urandom_range(99);
      page  = pick_page();
      moves = {$urandom, $urandom};
      seg   = ($urandom_range(9) != 0) ? SEG_W'($urandom) :
              ($urandom_range(1) ? ALL_SEGS : '0);
      if (roll < (fill_mode ? 75 : 35)) begin
        op = OP_INSERT;
        // fresh ascending keys push the table toward full
        if (fill_mode && $urandom_range(9) < 7) begin
          page = key_base + fill_cursor * key_stride;
          fill_cursor++;
        end
      end else if (roll >= (fill_mode ? 98 : 90)) begin
        op = OP_INVALIDATE;
        if ($urandom_range(99) < (fill_mode ? 10 : 30)) begin
          // new move generation: clears the table
          case ($urandom_range(3))
            0:       moves = {$urandom, $urandom};
            1:       moves = cache_tracker.move_gen + 1;
            2:       moves = $urandom_range(1) ? ALL_MOVES : '0;
            default: moves = cache_tracker.move_gen ^ (64'd1 << $urandom_range(63));
          endcase
          if ($urandom_range(1)) rebase_keys();
        end else begin
          // same generation: advance, hold or pull back the oldest start
          moves = cache_tracker.move_gen;
          case ($urandom_range(5))
            0, 1: page = key_base + $urandom_range(255) * key_stride;
            2, 3: page = cache_tracker.oldest_page + $urandom_range(4) * key_stride;
            4:    page = cache_tracker.oldest_page - $urandom_range(3);
            default: ;
          endcase
        end
      end else begin
        op = $urandom_range(1) ? OP_FLOOR : OP_EXACT;
      end
      send_item(op, page, seg, moves);
    end
  endtask

  initial begin
    int idle_plan [8];
    bit fill_plan [8];
    logic [MOVE_W-1:0] cfg_value;
    idle_plan = '{0, 77, 0, 11, 77, 0, 11, 77};
    fill_plan = '{1, 0, 0, 1, 1, 0, 0, 0};

    rst_n             = 1'b0;
    start             = 1'b0;
    in_operation      = OP_EXACT;
    in_page_number    = '0;
    in_segment_number = '0;
    in_move_count     = '0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    idle_pct          = 0;
    rebase_keys();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // wait out the clearing pass
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);
    write_move_count('0);

    // Directed: empty table, extremes, overwrite, purge, clear
    send_item(OP_EXACT,      '0,           '0,            '0);
    send_item(OP_FLOOR,      ALL_PAGES,    '0,            '0);
    send_item(OP_INSERT,     '0,           ALL_SEGS,      ALL_MOVES);
    send_item(OP_INSERT,     ALL_PAGES,    '0,            '0);
    send_item(OP_EXACT,      ALL_PAGES,    ALL_SEGS,      '0);
    send_item(OP_EXACT,      '0,           '0,            '0);
    send_item(OP_FLOOR,      64'd5,        '0,            '0);
    send_item(OP_FLOOR,      ALL_PAGES,    '0,            '0);
    send_item(OP_INSERT,     64'd1000,     32'h0000_1234, '0);
    send_item(OP_INSERT,     64'd1000,     32'h0000_ABCD, '0);
    send_item(OP_FLOOR,      64'd1500,     '0,            '0);
    send_item(OP_EXACT,      64'd999,      '0,            '0);
    send_item(OP_INVALIDATE, '0,           '0,            '0);
    send_item(OP_INVALIDATE, 64'd500,      '0,            '0);
    send_item(OP_INSERT,     64'd10,       32'h5A5A_5A5A, '0);
    send_item(OP_FLOOR,      64'd100,      '0,            '0);
    send_item(OP_INVALIDATE, 64'd400,      '0,            '0);
    send_item(OP_FLOOR,      64'd9,        '0,            '0);
    send_item(OP_INVALIDATE, HIGH_PAGE,    '0,            ALL_MOVES);
    send_item(OP_FLOOR,      ALL_PAGES,    '0,            '0);
    send_item(OP_INSERT,     HIGH_PAGE,    32'h5555_AAAA, '0);
    send_item(OP_FLOOR,      ALL_PAGES,    '0,            '0);
    send_item(OP_EXACT,      HIGH_PAGE,    '0,            '0);

    // Random phases, each with its own move count and idling
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0:       cfg_value = ALL_MOVES;
        2:       cfg_value = '0;
        6:       cfg_value = 64'd1;
        default: cfg_value = {$urandom, $urandom};
      endcase
      write_move_count(cfg_value);
      rebase_keys();
      idle_pct = idle_plan[ph];
      run_phase(250, fill_plan[ph]);
    end

    settle();
    repeat (SLFC_ENTRIES + 8) @(posedge clk);
    cache_tracker.close_out();
    if (cache_tracker.error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### filelist.f
rtl/core/slfc_pkg.sv
rtl/core/slfc_ram.sv
rtl/core/slfc_cmp.sv
rtl/core/segment_location_floor_cache.sv
rtl/core/slfc_checker.sv
bench/tb_top.sv
